// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every cycle outside reset.
`define PFLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfls_pkg.sv =====
package pfls_pkg;

  localparam int unsigned SCORE_W   = 20;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned ENTRY_W   = 6;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned FCNT_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_COUNT = 2'd1;
  localparam logic [CFG_DAT_W-1:0] ARCH_COUNT_RST = 6'd32;

  typedef struct packed {
    logic load_we;
    logic run_init;
    logic pass_start;
    logic cmp_en;
    logic cnt_clr;
    logic cnt_en;
    logic sum_en;
    logic emit_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic skip_i;
    logic hit_b;
    logic front;
    logic none_left;
    logic end_run;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/pfls_ram.sv =====
module pfls_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 44,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/pfls_dp.sv =====
`include "assert_macros.svh"

module pfls_dp #(
  parameter int unsigned POP_SIZE = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfls_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(2*POP_SIZE)-1:0]    row_i_i,
  input  logic [$clog2(2*POP_SIZE)-1:0]    rd_j_i,
  input  logic [$clog2(2*POP_SIZE)-1:0]    cmp_j_i,
  input  logic [$clog2(2*POP_SIZE)-1:0]    sweep_i,
  input  logic [pfls_pkg::SCORE_W-1:0]     score_i,
  input  logic [pfls_pkg::TIME_W-1:0]      cost_time_i,
  input  logic                             cfg_we_i,
  input  logic [pfls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfls_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic                             out_ready_i,
  output pfls_pkg::stat_t                  stat_o,
  output logic                             out_valid_o,
  output logic [pfls_pkg::ENTRY_W-1:0]     entry_index_o,
  output logic [pfls_pkg::RANK_W-1:0]      front_rank_o,
  output logic [pfls_pkg::FCNT_W-1:0]      first_front_count_o,
  output logic                             last_o
);

  localparam int unsigned TOTAL = 2 * POP_SIZE;
  localparam int unsigned IW    = $clog2(TOTAL);
  localparam int unsigned CW    = $clog2(TOTAL + 1);
  localparam int unsigned PW    = $clog2(POP_SIZE + 1);
  localparam int unsigned DW    = pfls_pkg::SCORE_W + pfls_pkg::TIME_W;

  typedef enum logic [1:0] {REL_NONE, REL_A, REL_B, REL_SAME} rel_e;

  function automatic rel_e rel_of(input logic [pfls_pkg::SCORE_W-1:0] sa,
                                  input logic [pfls_pkg::SCORE_W-1:0] sb,
                                  input logic [pfls_pkg::TIME_W-1:0]  ta,
                                  input logic [pfls_pkg::TIME_W-1:0]  tb);
    rel_e r;
    if (sa == sb && ta == tb) begin
      r = REL_SAME;
    end else if (sa >= sb && ta <= tb) begin
      r = REL_A;
    end else if (sa <= sb && ta >= tb) begin
      r = REL_B;
    end else begin
      r = REL_NONE;
    end
    return r;
  endfunction

  logic                        arch_mode_q;
  logic [pfls_pkg::CFG_DAT_W-1:0] arch_count_q;
  logic [TOTAL-1:0]            placed_q;
  logic [TOTAL-1:0]            mark_q;
  logic [TOTAL-1:0]            excl;
  logic [PW-1:0]               pass_q;
  logic [CW-1:0]               placed_total_q;
  logic [CW-1:0]               cnt_q;
  logic [CW-1:0]               first_q;
  logic [IW-1:0]               last_idx_q;
  logic                        remain_q;
  logic                        end_q;
  logic                        out_valid_q;
  logic [IW-1:0]               out_idx_q;
  logic [PW-1:0]               out_rank_q;
  logic [CW-1:0]               out_first_q;
  logic                        out_last_q;
  logic [DW-1:0]               rd_a;
  logic [DW-1:0]               rd_b;
  rel_e                        rel;
  logic                        skip_j;
  logic                        front_bit;
  logic                        out_free;
  logic [CW:0]                 tot_sum;

  pfls_ram #(
    .DEPTH (TOTAL),
    .WIDTH (DW),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load_we),
    .waddr_i   (sweep_i),
    .wdata_i   ({score_i, cost_time_i}),
    .raddr_a_i (row_i_i),
    .raddr_b_i (rd_j_i),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign rel = rel_of(rd_a[DW-1 -: pfls_pkg::SCORE_W], rd_b[DW-1 -: pfls_pkg::SCORE_W],
                      rd_a[pfls_pkg::TIME_W-1:0], rd_b[pfls_pkg::TIME_W-1:0]);

  assign skip_j    = mark_q[cmp_j_i] | placed_q[cmp_j_i];
  assign front_bit = ~mark_q[sweep_i] & ~placed_q[sweep_i];
  assign out_free  = ~out_valid_q | out_ready_i;
  assign tot_sum   = {1'b0, placed_total_q} + {1'b0, cnt_q};

  always_comb begin
    for (int unsigned k = 0; k < TOTAL; k++) begin
      excl[k] = arch_mode_q && (32'(arch_count_q) <= k) && (k < POP_SIZE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_mode_q  <= 1'b0;
      arch_count_q <= pfls_pkg::ARCH_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfls_pkg::CFG_ARCH_MODE:  arch_mode_q  <= cfg_data_i[0];
        pfls_pkg::CFG_ARCH_COUNT: arch_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q       <= '0;
      mark_q         <= '0;
      pass_q         <= '0;
      placed_total_q <= '0;
      cnt_q          <= '0;
      first_q        <= '0;
      last_idx_q     <= '0;
      remain_q       <= 1'b0;
      end_q          <= 1'b0;
    end else begin
      if (cmd_i.run_init) begin
        placed_q       <= excl;
        pass_q         <= '0;
        placed_total_q <= '0;
        first_q        <= '0;
      end
      if (cmd_i.pass_start) begin
        mark_q <= '0;
        pass_q <= pass_q + 1'b1;
      end
      if (cmd_i.cmp_en && !skip_j) begin
        case (rel)
          REL_SAME: placed_q[cmp_j_i] <= 1'b1;
          REL_A:    mark_q[cmp_j_i]   <= 1'b1;
          REL_B:    mark_q[row_i_i]   <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.cnt_clr) begin
        cnt_q      <= '0;
        remain_q   <= 1'b0;
        last_idx_q <= '0;
      end
      if (cmd_i.cnt_en) begin
        if (front_bit) begin
          cnt_q      <= cnt_q + 1'b1;
          last_idx_q <= sweep_i;
        end
        if (mark_q[sweep_i] && !placed_q[sweep_i]) begin
          remain_q <= 1'b1;
        end
      end
      if (cmd_i.sum_en) begin
        end_q <= (tot_sum >= (CW+1)'(POP_SIZE)) || (pass_q == PW'(POP_SIZE)) || !remain_q;
        placed_total_q <= tot_sum[CW-1:0];
        if (pass_q == PW'(1)) begin
          first_q <= cnt_q;
        end
      end
      if (cmd_i.commit) begin
        placed_q <= placed_q | ~mark_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      out_idx_q   <= sweep_i;
      out_rank_q  <= pass_q;
      out_first_q <= first_q;
      out_last_q  <= end_q && (sweep_i == last_idx_q);
    end
  end

  assign stat_o.skip_i    = mark_q[row_i_i] | placed_q[row_i_i];
  assign stat_o.hit_b     = ~skip_j & (rel == REL_B);
  assign stat_o.front     = front_bit;
  assign stat_o.none_left = &placed_q;
  assign stat_o.end_run   = end_q;
  assign stat_o.out_free  = out_free;

  assign out_valid_o         = out_valid_q;
  assign entry_index_o       = pfls_pkg::ENTRY_W'(out_idx_q);
  assign front_rank_o        = pfls_pkg::RANK_W'(out_rank_q);
  assign first_front_count_o = pfls_pkg::FCNT_W'(out_first_q);
  assign last_o              = out_last_q;

  `PFLS_ASSERT(a_cmp_not_self, !cmd_i.cmp_en || (cmp_j_i != row_i_i), "entry compared with itself")
  `PFLS_ASSERT(a_total_bound, placed_total_q <= CW'(TOTAL), "placed total beyond entry count")
  `PFLS_ASSERT_NEXT(a_emit_valid, cmd_i.emit_en, out_valid_q, "emitted result not presented")

endmodule

// ===== hdl/pfls_ctrl.sv =====
`include "assert_macros.svh"

module pfls_ctrl #(
  parameter int unsigned POP_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  pfls_pkg::stat_t               stat_i,
  output logic                          in_ready_o,
  output pfls_pkg::cmd_t                cmd_o,
  output logic [$clog2(2*POP_SIZE)-1:0] row_o,
  output logic [$clog2(2*POP_SIZE)-1:0] rd_j_o,
  output logic [$clog2(2*POP_SIZE)-1:0] cmp_j_o,
  output logic [$clog2(2*POP_SIZE)-1:0] sweep_o
);

  localparam int unsigned TOTAL = 2 * POP_SIZE;
  localparam int unsigned IW    = $clog2(TOTAL);
  localparam int unsigned CW    = $clog2(TOTAL + 1);
  localparam logic [IW-1:0] LAST = IW'(TOTAL - 1);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_PASS, S_ROW, S_SCAN, S_COUNT, S_SUM, S_EMIT, S_COMMIT
  } state_e;

  state_e         state_q, state_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  i_q, i_d;
  logic [CW-1:0]  j_q, j_d;
  logic           cmp_v_q, cmp_v_d;
  logic [IW-1:0]  cmp_j_q, cmp_j_d;
  logic [IW-1:0]  rd_j;
  pfls_pkg::cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    idx_d   = idx_q;
    i_d     = i_q;
    j_d     = j_q;
    cmp_v_d = cmp_v_q;
    cmp_j_d = cmp_j_q;
    rd_j    = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd.load_we = 1'b1;
          if (idx_q == LAST) begin
            idx_d   = '0;
            state_d = S_INIT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.run_init = 1'b1;
        state_d      = S_PASS;
      end
      S_PASS: begin
        if (stat_i.none_left) begin
          state_d = S_LOAD;
        end else begin
          cmd.pass_start = 1'b1;
          cmd.cnt_clr    = 1'b1;
          i_d            = '0;
          state_d        = S_ROW;
        end
      end
      S_ROW: begin
        if (i_q == LAST) begin
          idx_d   = '0;
          state_d = S_COUNT;
        end else if (stat_i.skip_i) begin
          i_d = i_q + 1'b1;
        end else begin
          rd_j    = i_q + 1'b1;
          cmp_j_d = i_q + 1'b1;
          cmp_v_d = 1'b1;
          j_d     = CW'(i_q) + CW'(2);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.cmp_en = cmp_v_q;
        if (!cmp_v_q || stat_i.hit_b) begin
          i_d     = i_q + 1'b1;
          state_d = S_ROW;
        end else if (j_q < CW'(TOTAL)) begin
          rd_j    = j_q[IW-1:0];
          cmp_j_d = j_q[IW-1:0];
          j_d     = j_q + 1'b1;
        end else begin
          cmp_v_d = 1'b0;
        end
      end
      S_COUNT: begin
        cmd.cnt_en = 1'b1;
        if (idx_q == LAST) begin
          idx_d   = '0;
          state_d = S_SUM;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.front || stat_i.out_free) begin
          cmd.emit_en = stat_i.front;
          if (idx_q == LAST) begin
            idx_d   = '0;
            state_d = S_COMMIT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_d    = stat_i.end_run ? S_LOAD : S_PASS;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      cmp_v_q <= 1'b0;
      cmp_j_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cmp_v_q <= cmp_v_d;
      cmp_j_q <= cmp_j_d;
    end
  end

  assign in_ready_o = (state_q == S_LOAD);
  assign cmd_o      = cmd;
  assign row_o      = i_q;
  assign rd_j_o     = rd_j;
  assign cmp_j_o    = cmp_j_q;
  assign sweep_o    = idx_q;

  `PFLS_ASSERT_NEXT(a_break_row, (state_q == S_SCAN) && cmp_v_q && stat_i.hit_b, state_q == S_ROW, "row scan did not stop on dominance")
  `PFLS_ASSERT(a_j_ahead, (state_q != S_SCAN) || !cmp_v_q || (cmp_j_q > i_q), "compare index not past row index")

endmodule

// ===== hdl/pareto_front_layer_sort.sv =====
// Two-objective layered Pareto sort of 2*POP_SIZE candidates. Candidates
// (score to maximise, cost_time to minimise) are loaded one per cycle; after
// the last one the block peels fronts pass by pass and emits one result per
// placed entry, front order then index order, last set on the final one.
// Each pass walks the rows in index order, scanning the later entries
// against every row still unplaced and unmarked when reached, then runs a
// count sweep and an emit sweep; there are up to POP_SIZE passes. The emit
// sweep stalls while the result side is not ready. Sorting uses a single
// comparator, fed one pair per cycle from the two read ports of the
// candidate memory. No input is taken while a run is sorting or emitting.
// Configuration: index 0 archive_mode, index 1 archive_count.
module pareto_front_layer_sort #(
  parameter int unsigned POP_SIZE = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pfls_pkg::SCORE_W-1:0]     score_i,
  input  logic [pfls_pkg::TIME_W-1:0]      cost_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pfls_pkg::ENTRY_W-1:0]     entry_index_o,
  output logic [pfls_pkg::RANK_W-1:0]      front_rank_o,
  output logic [pfls_pkg::FCNT_W-1:0]      first_front_count_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pfls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfls_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(2 * POP_SIZE);

  pfls_pkg::cmd_t  cmd;
  pfls_pkg::stat_t stat;
  logic [IW-1:0]   row;
  logic [IW-1:0]   rd_j;
  logic [IW-1:0]   cmp_j;
  logic [IW-1:0]   sweep;

  assign cfg_ready_o = 1'b1;

  pfls_ctrl #(
    .POP_SIZE (POP_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .row_o      (row),
    .rd_j_o     (rd_j),
    .cmp_j_o    (cmp_j),
    .sweep_o    (sweep)
  );

  pfls_dp #(
    .POP_SIZE (POP_SIZE)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .row_i_i             (row),
    .rd_j_i              (rd_j),
    .cmp_j_i             (cmp_j),
    .sweep_i             (sweep),
    .score_i             (score_i),
    .cost_time_i         (cost_time_i),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_ready_i         (out_ready_i),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .entry_index_o       (entry_index_o),
    .front_rank_o        (front_rank_o),
    .first_front_count_o (first_front_count_o),
    .last_o              (last_o)
  );

endmodule

// ===== dv/pareto_front_layer_sort_test.sv =====
`timescale 1ns / 1ps

module pareto_front_layer_sort_test;

  localparam int unsigned SCORE_W   = pfls_pkg::SCORE_W;
  localparam int unsigned TIME_W    = pfls_pkg::TIME_W;
  localparam int unsigned ENTRY_W   = pfls_pkg::ENTRY_W;
  localparam int unsigned RANK_W    = pfls_pkg::RANK_W;
  localparam int unsigned FCNT_W    = pfls_pkg::FCNT_W;
  localparam int unsigned CFG_IDX_W = pfls_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W = pfls_pkg::CFG_DAT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_MODE  = pfls_pkg::CFG_ARCH_MODE;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_COUNT = pfls_pkg::CFG_ARCH_COUNT;
  localparam logic [CFG_DAT_W-1:0] ARCH_COUNT_RST = pfls_pkg::ARCH_COUNT_RST;

  localparam int unsigned POP = 32;
  localparam int unsigned SLOTS = 2 * POP;
  localparam int unsigned RUNS = 2;
  localparam int unsigned SCORE_MAX = (1 << SCORE_W) - 1;
  localparam int unsigned TIME_MAX = (1 << TIME_W) - 1;
  localparam longint unsigned LIMIT_NS = 64'd15_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  cost_time;
  } cand_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic [RANK_W-1:0]  front_rank;
    logic [FCNT_W-1:0]  first_front_count;
    logic               last;
  } placement_t;

  typedef enum {DOM_NONE, DOM_FIRST, DOM_SECOND, DOM_EQUAL} dom_e;
  typedef enum {MIX_NARROW, MIX_CHAIN, MIX_SPREAD, MIX_FULL, MIX_ANY} mix_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [SCORE_W-1:0]   score_i = '0;
  logic [TIME_W-1:0]    cost_time_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ENTRY_W-1:0]   entry_index_o;
  logic [RANK_W-1:0]    front_rank_o;
  logic [FCNT_W-1:0]    first_front_count_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  pareto_front_layer_sort #(
    .POP_SIZE(POP)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .score_i            (score_i),
    .cost_time_i        (cost_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .entry_index_o      (entry_index_o),
    .front_rank_o       (front_rank_o),
    .first_front_count_o(first_front_count_o),
    .last_o             (last_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cand_t        pending[$];
  placement_t   front_results[$];
  logic [SCORE_W-1:0] score_mem [SLOTS];
  logic [TIME_W-1:0]  time_mem [SLOTS];
  logic         arch_mode = 1'b0;
  logic [CFG_DAT_W-1:0] arch_count = ARCH_COUNT_RST;
  int unsigned  load_pos = 0;
  int unsigned  n_loaded = 0;
  int unsigned  mismatches = 0;
  logic         in_took = 1'b0;
  logic         out_took = 1'b0;
  int unsigned  in_wait = 0;
  int unsigned  out_hold = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;
  cand_t        nxt;
  placement_t   want_r;

  function automatic dom_e dominance(int a, int b);
    int sum = 0;
    if (score_mem[a] == score_mem[b] && time_mem[a] == time_mem[b]) return DOM_EQUAL;
    if (score_mem[a] > score_mem[b]) sum++;
    else if (score_mem[a] < score_mem[b]) sum--;
    if (time_mem[a] < time_mem[b]) sum++;
    else if (time_mem[a] > time_mem[b]) sum--;
    if (sum > 0) return DOM_FIRST;
    if (sum < 0) return DOM_SECOND;
    return DOM_NONE;
  endfunction

  // peel fronts over the loaded set and queue one placement per placed entry
  function automatic void sort_fronts();
    bit gone [SLOTS];
    bit marked [SLOTS];
    int unsigned front_no [SLOTS];
    int unsigned pass, placed, first_cnt, cnt, k;
    dom_e rel;
    placement_t res;
    pass = 0;
    placed = 0;
    first_cnt = 0;
    k = 0;
    for (int i = 0; i < SLOTS; i++) begin
      gone[i] = 1'b0;
      front_no[i] = 0;
    end
    if (arch_mode) begin
      for (int i = int'(arch_count); i < POP; i++) gone[i] = 1'b1;
    end
    while (placed < POP && pass < POP) begin
      pass++;
      cnt = 0;
      for (int i = 0; i < SLOTS; i++) marked[i] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (gone[i]) marked[i] = 1'b1;
        if (!marked[i]) begin
          for (int j = i + 1; j < SLOTS; j++) begin
            if (!marked[j] && !gone[j]) begin
              rel = dominance(i, j);
              if (rel == DOM_EQUAL) begin
                gone[j] = 1'b1;
              end else if (rel == DOM_FIRST) begin
                marked[j] = 1'b1;
              end else if (rel == DOM_SECOND) begin
                marked[i] = 1'b1;
                break;
              end
            end
          end
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!marked[i]) begin
          gone[i] = 1'b1;
          front_no[i] = pass;
          cnt++;
        end
      end
      if (pass == 1) first_cnt = cnt;
      placed += cnt;
    end
    for (int f = 1; f <= pass; f++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (front_no[i] == f) begin
          k++;
          res.entry_index = ENTRY_W'(i);
          res.front_rank = RANK_W'(f);
          res.first_front_count = FCNT_W'(first_cnt);
          res.last = (k == placed);
          front_results.push_back(res);
        end
      end
    end
  endfunction

  function automatic cand_t draw_item(mix_e mix);
    cand_t c;
    int unsigned v;
    mix_e m;
    m = mix;
    if (m == MIX_ANY) m = mix_e'($urandom_range(0, 3));
    if ((m == MIX_NARROW || m == MIX_CHAIN) && $urandom_range(0, 7) == 0) m = MIX_FULL;
    v = $urandom_range(0, 65535);
    case (m)
      MIX_NARROW: begin
        c.score = SCORE_W'($urandom_range(0, 7));
        c.cost_time = TIME_W'($urandom_range(0, 7));
      end
      MIX_CHAIN: begin
        c.score = SCORE_W'(v << 4);
        c.cost_time = TIME_W'((65535 - v) << 8);
      end
      MIX_SPREAD: begin
        c.score = SCORE_W'((v << 4) | $urandom_range(0, 15));
        c.cost_time = TIME_W'((v << 8) | $urandom_range(0, 255));
      end
      default: begin
        c.score = SCORE_W'($urandom_range(0, SCORE_MAX));
        c.cost_time = TIME_W'($urandom_range(0, TIME_MAX));
      end
    endcase
    return c;
  endfunction

  task automatic queue_cand(input int unsigned s, input int unsigned t);
    cand_t c;
    c.score = SCORE_W'(s);
    c.cost_time = TIME_W'(t);
    pending.push_back(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ARCH_MODE:  arch_mode <= cfg_data_i[0];
        CFG_ARCH_COUNT: arch_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side: capture accepted candidates
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      score_mem[load_pos] = score_i;
      time_mem[load_pos] = cost_time_i;
      load_pos++;
      n_loaded++;
      if (load_pos == SLOTS) begin
        sort_fronts();
        load_pos = 0;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_took)) begin
      if (in_wait != 0) begin
        in_valid_i <= 1'b0;
        in_wait--;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        score_i <= nxt.score;
        cost_time_i <= nxt.cost_time;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (out_hold != 0) begin
        out_ready_i <= 1'b0;
        out_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_took <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (front_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected transaction, expected none, got entry %0d rank %0d",
                 $time, entry_index_o, front_rank_o);
      end else begin
        want_r = front_results.pop_front();
        check_field("entry_index", 32'(want_r.entry_index), 32'(entry_index_o));
        check_field("front_rank", 32'(want_r.front_rank), 32'(front_rank_o));
        check_field("first_front_count", 32'(want_r.first_front_count),
                    32'(first_front_count_o));
        check_field("last", 32'(want_r.last), 32'(last_o));
      end
    end
  end

  initial begin
    mix_e mix;
    logic [CFG_DAT_W-1:0] mode_v, count_v;
    int unsigned target;
    target = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int run = 0; run < RUNS; run++) begin
      case (run)
        0: begin
          mode_v = '0;
          count_v = ARCH_COUNT_RST;
          mix = MIX_ANY;
        end
        1: begin
          mode_v = CFG_DAT_W'(1);
          count_v = CFG_DAT_W'($urandom_range(1, POP - 1));
          mix = MIX_NARROW;
        end
        2: begin
          mode_v = CFG_DAT_W'(1);
          count_v = '0;
          mix = MIX_CHAIN;
        end
        3: begin
          mode_v = CFG_DAT_W'(1);
          count_v = $urandom_range(0, 1) ? ARCH_COUNT_RST : 6'd63;
          mix = MIX_ANY;
        end
        default: begin
          mode_v = '0;
          count_v = CFG_DAT_W'($urandom_range(0, 63));
          mix = MIX_SPREAD;
        end
      endcase
      if (run != 0) repeat (16) @(negedge clk_i);
      if (run == 1) write_reg(CFG_SPARE, CFG_DAT_W'($urandom_range(0, 63)));
      write_reg(CFG_ARCH_MODE, mode_v);
      write_reg(CFG_ARCH_COUNT, count_v);
      if (run == 0) begin
        queue_cand(0, 0);
        queue_cand(SCORE_MAX, TIME_MAX);
        queue_cand(SCORE_MAX, 0);
        queue_cand(SCORE_MAX, 0);
        queue_cand(0, TIME_MAX);
        queue_cand(0, TIME_MAX);
        queue_cand(1000, 500);
        queue_cand(1000, 499);
        queue_cand(1001, 500);
        queue_cand(999, 501);
        queue_cand(1001, 499);
        queue_cand(2000, 2000);
        queue_cand(3000, 3000);
        queue_cand(4000, 4000);
        queue_cand('h55555, 'hAAAAAA);
        queue_cand('hAAAAA, 'h555555);
        queue_cand(1000000, 1000);
        queue_cand(1000, 500);
        queue_cand(0, 1);
        queue_cand(1, 0);
        queue_cand(SCORE_MAX, 1);
        queue_cand(SCORE_MAX - 1, 0);
        queue_cand(512, 'h800000);
        queue_cand('h80000, 1);
        queue_cand(0, 0);
      end
      while (pending.size() < SLOTS) pending.push_back(draw_item(mix));
      target += SLOTS;
      while (n_loaded < target || front_results.size() != 0) @(negedge clk_i);
    end
    repeat (64) @(negedge clk_i);
    if (mismatches == 0 && front_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
